[sv/ptm_pkg.sv]
// Package for the packet throughput meter: transaction payload types and op codes.
// No dependencies; imported by packet_throughput_meter_core.
`default_nettype none

package ptm_pkg;

    typedef enum logic [1:0] {
        OP_PACKET = 2'd0,
        OP_TICK   = 2'd1,
        OP_STOP   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [0:0] {
        CFG_WINDOW_LENGTH = 1'b0,
        CFG_IDLE_TIMEOUT  = 1'b1
    } cfg_reg_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [15:0] WINDOW_LENGTH_RESET = 16'd1000;
    localparam logic [15:0] IDLE_TIMEOUT_RESET  = 16'd1000;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] payload_length;
    } in_t;

    typedef struct packed {
        logic        is_final;
        logic [31:0] byte_count;
        logic [31:0] span_ms;
        logic [31:0] rate_kbps;
    } out_t;

endpackage

`default_nettype wire

[sv/packet_throughput_meter_core.sv]
// Packet throughput meter: run and window byte counters, idle timeout and a
// bit-serial restoring divider that turns bytes*8 over milliseconds into kbit/s.
// An item with no report is taken in ST_IDLE alone; an item that reports passes through
// ST_IDLE, ST_DIV (one quotient bit per cycle) and ST_DONE, where the output register
// may wait for out_ready. Throughput: one item at a time.
// Reset: asynchronous, active low; clears counters and times, both registers to 1000 ms.
`default_nettype none

module packet_throughput_meter_core
    import ptm_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_t                    in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_t                        out_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int DW    = COUNT_WIDTH + 3;
    localparam int CNT_W = $clog2(DW + 1);
    localparam int SUM_W = COUNT_WIDTH + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic                    measuring_reg, measuring_next;
    logic [31:0]             time_now_reg, time_now_next;
    logic [31:0]             run_start_reg, run_start_next;
    logic [31:0]             last_pkt_reg, last_pkt_next;
    logic [31:0]             win_start_reg, win_start_next;
    logic [COUNT_WIDTH-1:0]  run_bytes_reg, run_bytes_next;
    logic [COUNT_WIDTH-1:0]  win_bytes_reg, win_bytes_next;
    logic [15:0]             idle_count_reg, idle_count_next;
    logic [15:0]             win_len_reg, win_len_next;
    logic [15:0]             idle_to_reg, idle_to_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;

    // divider and report payload
    logic [DW-1:0]           dvd_reg, dvd_next;
    logic [31:0]             divisor_reg, divisor_next;
    logic [31:0]             rem_reg, rem_next;
    logic [31:0]             quo_reg, quo_next;
    logic                    ovf_reg, ovf_next;
    logic                    rep_final_reg, rep_final_next;
    logic [31:0]             rep_bytes_reg, rep_bytes_next;
    out_t                    out_data_reg, out_data_next;

    logic                    accept;
    logic                    start;
    logic [COUNT_WIDTH-1:0]  run_base, win_base;
    logic [COUNT_WIDTH-1:0]  run_sum, win_sum;
    logic [31:0]             win_start_eff;
    logic [31:0]             win_ms;
    logic                    win_close;
    logic [15:0]             idle_inc;
    logic                    timeout;
    logic                    launch;
    logic                    launch_final;
    logic [COUNT_WIDTH-1:0]  launch_bytes;
    logic [31:0]             launch_span;
    logic [63:0]             bytes_ext;
    logic [32:0]             rem_shift;
    logic                    rem_ge;

    function automatic logic [COUNT_WIDTH-1:0] sat_add(
        input logic [COUNT_WIDTH-1:0] a,
        input logic [15:0]            b
    );
        logic [SUM_W-1:0] s;
        s = {1'b0, a} + SUM_W'(b);
        if (s[SUM_W-1])
            return '1;
        return s[COUNT_WIDTH-1:0];
    endfunction

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // packet path
    assign start         = !measuring_reg;
    assign run_base      = start ? '0 : run_bytes_reg;
    assign win_base      = start ? '0 : win_bytes_reg;
    assign win_start_eff = start ? time_now_reg : win_start_reg;
    assign run_sum       = sat_add(run_base, in_data.payload_length);
    assign win_sum       = sat_add(win_base, in_data.payload_length);
    assign win_ms        = time_now_reg - win_start_eff;
    assign win_close     = (win_ms >= {16'd0, win_len_reg});

    // tick path
    assign idle_inc = (idle_count_reg == 16'hFFFF) ? idle_count_reg : idle_count_reg + 16'd1;
    assign timeout  = (idle_inc >= idle_to_reg);

    // shared divider step
    assign rem_shift = {rem_reg, dvd_reg[DW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});

    assign bytes_ext = 64'(launch_bytes);

    always_comb
    begin
        state_next      = state_reg;
        measuring_next  = measuring_reg;
        time_now_next   = time_now_reg;
        run_start_next  = run_start_reg;
        last_pkt_next   = last_pkt_reg;
        win_start_next  = win_start_reg;
        run_bytes_next  = run_bytes_reg;
        win_bytes_next  = win_bytes_reg;
        idle_count_next = idle_count_reg;
        win_len_next    = win_len_reg;
        idle_to_next    = idle_to_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        dvd_next        = dvd_reg;
        divisor_next    = divisor_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        ovf_next        = ovf_reg;
        rep_final_next  = rep_final_reg;
        rep_bytes_next  = rep_bytes_reg;
        out_data_next   = out_data_reg;
        launch          = 1'b0;
        launch_final    = 1'b0;
        launch_bytes    = run_bytes_reg;
        launch_span     = last_pkt_reg - run_start_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INDEX_W'(CFG_WINDOW_LENGTH): win_len_next = cfg_data;
                CFG_INDEX_W'(CFG_IDLE_TIMEOUT):  idle_to_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(in_data.op))
                        OP_PACKET:
                        begin
                            measuring_next  = 1'b1;
                            if (start)
                                run_start_next = time_now_reg;
                            last_pkt_next   = time_now_reg;
                            idle_count_next = 16'd0;
                            run_bytes_next  = run_sum;
                            if (win_close)
                            begin
                                launch         = 1'b1;
                                launch_bytes   = win_sum;
                                launch_span    = win_ms;
                                win_start_next = time_now_reg;
                                win_bytes_next = '0;
                            end
                            else
                            begin
                                win_start_next = win_start_eff;
                                win_bytes_next = win_sum;
                            end
                        end
                        OP_TICK:
                        begin
                            time_now_next = time_now_reg + 32'd1;
                            if (measuring_reg)
                            begin
                                idle_count_next = idle_inc;
                                if (timeout)
                                begin
                                    launch         = 1'b1;
                                    launch_final   = 1'b1;
                                    measuring_next = 1'b0;
                                end
                            end
                        end
                        OP_STOP:
                        begin
                            if (measuring_reg)
                            begin
                                launch         = 1'b1;
                                launch_final   = 1'b1;
                                measuring_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                if (launch)
                begin
                    // zero span reports as one millisecond
                    divisor_next   = (launch_span == 32'd0) ? 32'd1 : launch_span;
                    dvd_next       = {launch_bytes, 3'b000};
                    rem_next       = '0;
                    quo_next       = '0;
                    ovf_next       = 1'b0;
                    cnt_next       = CNT_W'(DW);
                    rep_final_next = launch_final;
                    rep_bytes_next = (|bytes_ext[63:32]) ? 32'hFFFF_FFFF : bytes_ext[31:0];
                    state_next     = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? 32'(rem_shift - {1'b0, divisor_reg}) : rem_shift[31:0];
                quo_next = {quo_reg[30:0], rem_ge};
                // sticky saturation once a quotient bit passes bit 31
                ovf_next = ovf_reg | quo_reg[31];
                dvd_next = {dvd_reg[DW-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next.is_final   = rep_final_reg;
                    out_data_next.byte_count = rep_bytes_reg;
                    out_data_next.span_ms    = divisor_reg;
                    out_data_next.rate_kbps  = ovf_reg ? 32'hFFFF_FFFF : quo_reg;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            measuring_reg  <= 1'b0;
            time_now_reg   <= '0;
            run_start_reg  <= '0;
            last_pkt_reg   <= '0;
            win_start_reg  <= '0;
            run_bytes_reg  <= '0;
            win_bytes_reg  <= '0;
            idle_count_reg <= '0;
            win_len_reg    <= WINDOW_LENGTH_RESET;
            idle_to_reg    <= IDLE_TIMEOUT_RESET;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            measuring_reg  <= measuring_next;
            time_now_reg   <= time_now_next;
            run_start_reg  <= run_start_next;
            last_pkt_reg   <= last_pkt_next;
            win_start_reg  <= win_start_next;
            run_bytes_reg  <= run_bytes_next;
            win_bytes_reg  <= win_bytes_next;
            idle_count_reg <= idle_count_next;
            win_len_reg    <= win_len_next;
            idle_to_reg    <= idle_to_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg       <= dvd_next;
        divisor_reg   <= divisor_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        ovf_reg       <= ovf_next;
        rep_final_reg <= rep_final_next;
        rep_bytes_reg <= rep_bytes_next;
        out_data_reg  <= out_data_next;
    end

endmodule

`default_nettype wire

[tb/sv/ptm_report_checker.sv]
`timescale 1ns / 100ps
// Report checker for packet_throughput_meter_core: watches the input, report and register
// channels, predicts the window and end-of-run reports and compares them field by field.
// Depends on ptm_pkg for the transaction types, op codes and register indexes.

module ptm_report_checker
    import ptm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   in_ready,
    input  wire in_t                    in_data,
    input  wire logic                   out_valid,
    input  wire logic                   out_ready,
    input  wire out_t                   out_data,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          error_count,
    output int                          pending_reports
);

    localparam logic [63:0] MAX32 = 64'h0000_0000_FFFF_FFFF;

    int mismatches = 0;
    int queued = 0;

    logic [15:0] window_len_ms;
    logic [15:0] idle_limit_ms;
    logic        measuring;
    logic [31:0] time_now;
    logic [31:0] run_start;
    logic [31:0] last_packet;
    logic [31:0] window_start;
    logic [63:0] run_bytes;
    logic [63:0] window_bytes;
    logic [15:0] idle_count;

    out_t expected_reports[$];

    assign error_count     = mismatches;
    assign pending_reports = queued;

    function automatic logic [63:0] add_bytes(logic [63:0] total, logic [63:0] more);
        logic [63:0] sum;
        sum = total + more;
        return (sum > MAX32) ? MAX32 : sum;
    endfunction

    function automatic out_t rate_report(logic fin, logic [63:0] bytes, logic [31:0] span);
        out_t        rep;
        logic [31:0] span_nz;
        logic [63:0] rate;
        span_nz = (span == 32'd0) ? 32'd1 : span;
        rate = (bytes * 64'd8) / {32'd0, span_nz};
        rep.is_final   = fin;
        rep.byte_count = (bytes > MAX32) ? 32'hFFFF_FFFF : bytes[31:0];
        rep.span_ms    = span_nz;
        rep.rate_kbps  = (rate > MAX32) ? 32'hFFFF_FFFF : rate[31:0];
        return rep;
    endfunction

    function automatic bit close_run(output out_t rep);
        rep = '0;
        if (!measuring)
            return 1'b0;
        measuring = 1'b0;
        rep = rate_report(1'b1, run_bytes, last_packet - run_start);
        return 1'b1;
    endfunction

    // Advance the meter by one transaction; return 1 when it yields a report.
    function automatic bit meter_step(in_t item, output out_t rep);
        logic [31:0] win_ms;
        bit          has_report;
        has_report = 1'b0;
        rep = '0;
        case (item.op)
            OP_PACKET:
            begin
                if (!measuring)
                begin
                    measuring    = 1'b1;
                    run_bytes    = '0;
                    run_start    = time_now;
                    window_start = time_now;
                    window_bytes = '0;
                end
                run_bytes    = add_bytes(run_bytes, {48'd0, item.payload_length});
                window_bytes = add_bytes(window_bytes, {48'd0, item.payload_length});
                last_packet  = time_now;
                idle_count   = '0;
                win_ms = time_now - window_start;
                if (win_ms >= {16'd0, window_len_ms})
                begin
                    rep = rate_report(1'b0, window_bytes, win_ms);
                    window_start = time_now;
                    window_bytes = '0;
                    has_report = 1'b1;
                end
            end
            OP_TICK:
            begin
                time_now = time_now + 32'd1;
                if (measuring)
                begin
                    if (idle_count != 16'hFFFF)
                        idle_count = idle_count + 16'd1;
                    if (idle_count >= idle_limit_ms)
                        has_report = close_run(rep);
                end
            end
            OP_STOP:
                has_report = close_run(rep);
            default:
                ;
        endcase
        return has_report;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        out_t predicted;
        out_t want;
        if (!rst_n)
        begin
            window_len_ms = WINDOW_LENGTH_RESET;
            idle_limit_ms = IDLE_TIMEOUT_RESET;
            measuring     = 1'b0;
            time_now      = '0;
            run_start     = '0;
            last_packet   = '0;
            window_start  = '0;
            run_bytes     = '0;
            window_bytes  = '0;
            idle_count    = '0;
            expected_reports.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("report transaction with none expected: %p", out_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (out_data.is_final !== want.is_final)
                    begin
                        $error("is_final: expected %0d, got %0d",
                               want.is_final, out_data.is_final);
                        mismatches++;
                    end
                    if (out_data.byte_count !== want.byte_count)
                    begin
                        $error("byte_count: expected %0d, got %0d",
                               want.byte_count, out_data.byte_count);
                        mismatches++;
                    end
                    if (out_data.span_ms !== want.span_ms)
                    begin
                        $error("span_ms: expected %0d, got %0d",
                               want.span_ms, out_data.span_ms);
                        mismatches++;
                    end
                    if (out_data.rate_kbps !== want.rate_kbps)
                    begin
                        $error("rate_kbps: expected %0d, got %0d",
                               want.rate_kbps, out_data.rate_kbps);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_INDEX_W'(CFG_WINDOW_LENGTH))
                    window_len_ms = cfg_data;
                else if (cfg_index == CFG_INDEX_W'(CFG_IDLE_TIMEOUT))
                    idle_limit_ms = cfg_data;
            end
            if (in_valid && in_ready)
            begin
                if (meter_step(in_data, predicted))
                    expected_reports.push_back(predicted);
            end
        end
        queued = expected_reports.size();
    end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Top of the packet_throughput_meter_core testbench: clock, reset, stimulus with random
// sender bursts and receiver stalls, and the verdict. Needs ptm_pkg and ptm_report_checker.

module tb_top;
    import ptm_pkg::*;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 50;
    localparam int FLOOD_PACKETS   = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW      = CFG_INDEX_W'(CFG_WINDOW_LENGTH);
    localparam logic [CFG_INDEX_W-1:0] REG_IDLE        = CFG_INDEX_W'(CFG_IDLE_TIMEOUT);
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_t                    in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_t                   out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   hold_off_req;
    int                     error_count;
    int                     pending_reports;
    int                     idle_cycles = 0;

    always #6 clk = ~clk;

    packet_throughput_meter_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ptm_report_checker i_report_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .error_count     (error_count),
        .pending_reports (pending_reports)
    );

    // End the run when no channel moves a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Receiver: random stall modes in runs, plus one long hold-off on request.
    initial
    begin
        int  run_len;
        int  mode;
        bit  hold_off_done;
        out_ready = 1'b0;
        hold_off_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode    = $urandom_range(0, 2);
            run_len = $urandom_range(16, 96);
            repeat (run_len)
            begin
                @(negedge clk);
                if (hold_off_req && !hold_off_done)
                begin
                    out_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                    hold_off_done = 1'b1;
                end
                else if (mode == 0)
                    out_ready <= 1'b1;
                else if (mode == 1)
                    out_ready <= 1'($urandom_range(0, 1));
                else
                    out_ready <= ($urandom_range(0, 5) == 0);
            end
        end
    end

    function automatic in_t make_item(op_t op, logic [15:0] len);
        in_t item;
        item.op = op;
        item.payload_length = len;
        return item;
    endfunction

    // Mostly packets and ticks so runs and windows close often; a few stops and unused ops.
    function automatic in_t random_item();
        int          pick;
        int          kind;
        op_t         op;
        logic [15:0] len;
        pick = $urandom_range(0, 99);
        kind = $urandom_range(0, 7);
        if (pick < 50)
            op = OP_PACKET;
        else if (pick < 88)
            op = OP_TICK;
        else if (pick < 95)
            op = OP_STOP;
        else
            op = OP_NONE;
        if (kind == 0)
            len = 16'h0000;
        else if (kind == 1)
            len = 16'hFFFF;
        else
            len = 16'($urandom_range(0, 65535));
        return make_item(op, len);
    endfunction

    task automatic send_item(in_t item);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every predicted report, then let a report computation finish.
    task automatic wait_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reports != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(logic [15:0] window_ms, logic [15:0] timeout_ms, int count,
                             bit with_gaps, bit squeeze);
        int left;
        int burst;
        int gap;
        write_reg(REG_WINDOW, window_ms);
        write_reg(REG_IDLE, timeout_ms);
        if (squeeze)
            hold_off_req <= 1'b1;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst) send_item(random_item());
            left -= burst;
            gap = (!with_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        wait_quiet();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        hold_off_req = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: stop and unused op while idle, zero-span run.
        send_item(make_item(OP_STOP, 16'h0000));
        send_item(make_item(OP_NONE, 16'hFFFF));
        send_item(make_item(OP_TICK, 16'h0000));
        send_item(make_item(OP_PACKET, 16'h0000));
        send_item(make_item(OP_PACKET, 16'hFFFF));
        send_item(make_item(OP_STOP, 16'h0000));
        wait_quiet();

        // Zero window and zero timeout: every packet reports, first tick ends the run.
        write_reg(REG_WINDOW, 16'd0);
        write_reg(REG_IDLE, 16'd0);
        send_item(make_item(OP_PACKET, 16'hFFFF));
        send_item(make_item(OP_PACKET, 16'h0000));
        send_item(make_item(OP_TICK, 16'hFFFF));
        send_item(make_item(OP_TICK, 16'h0000));
        wait_quiet();

        // Window closes on a packet only, never on a tick; run ends on idle timeout.
        write_reg(REG_WINDOW, 16'd3);
        write_reg(REG_IDLE, 16'd5);
        send_item(make_item(OP_PACKET, 16'd100));
        send_item(make_item(OP_TICK, 16'h0000));
        send_item(make_item(OP_TICK, 16'h0000));
        send_item(make_item(OP_PACKET, 16'd200));
        send_item(make_item(OP_TICK, 16'h0000));
        send_item(make_item(OP_PACKET, 16'h5555));
        repeat (5) send_item(make_item(OP_TICK, 16'h0000));
        send_item(make_item(OP_PACKET, 16'hAAAA));
        send_item(make_item(OP_NONE, 16'h0000));
        send_item(make_item(OP_STOP, 16'h0000));
        wait_quiet();

        // Back-to-back full packets inside one long window, then a zero-span stop.
        write_reg(REG_WINDOW, 16'hFFFF);
        write_reg(REG_IDLE, 16'hFFFF);
        repeat (FLOOD_PACKETS) send_item(make_item(OP_PACKET, 16'hFFFF));
        send_item(make_item(OP_STOP, 16'h0000));
        wait_quiet();

        run_phase(16'd1, 16'hFFFF, 130, 1'b1, 1'b0);
        write_reg(CFG_SPARE_INDEX, 16'hFFFF);
        run_phase(16'd2, 16'd40, 150, 1'b1, 1'b1);
        run_phase(16'hFFFF, 16'd1, 100, 1'b1, 1'b0);
        run_phase(16'd0, 16'($urandom_range(0, 6)), 120, 1'b0, 1'b0);
        run_phase(16'($urandom_range(2, 8)), 16'($urandom_range(3, 15)), 150, 1'b1, 1'b0);
        run_phase(16'($urandom_range(1, 5)), 16'($urandom_range(1, 8)), 150, 1'b1, 1'b0);

        wait_quiet();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
